@@ hdl/ipv4_rx_header_classifier_unit_assert.svh @@
// Assertion macros shared by the classifier RTL.
// Both macros expect clk and rst_n in scope.
`ifndef IPV4_RX_HEADER_CLASSIFIER_UNIT_ASSERT_SVH
`define IPV4_RX_HEADER_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihc assertion failed: same-cycle implication");
`define IHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihc assertion failed: next-cycle implication");
`else
`define IHC_ASSERT_SAME(label, ante, cons)
`define IHC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/ihc_pkg.sv @@
package ihc_pkg;

  localparam int SLOT_REGS  = 4;
  localparam int PAIR_COUNT = 5;
  localparam int HW_COUNT   = 2 * PAIR_COUNT;

  localparam logic [15:0] HDR_BYTES     = 16'd20;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [15:0] FRAG_MF_MASK  = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
  localparam logic [15:0] ONES16        = 16'hffff;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [8:0]  SLOT_EMPTY    = 9'd256;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
  localparam logic [2:0] REG_SLOT_FIRST = 3'd1;
  localparam logic [2:0] REG_SLOT_LAST  = 3'd4;

  typedef enum logic [3:0] {
    V_SLOT        = 4'd0,
    V_ICMP        = 4'd1,
    V_SHORT       = 4'd2,
    V_VERSION     = 4'd3,
    V_OPTIONS     = 4'd4,
    V_FRAGMENT    = 4'd5,
    V_CHECKSUM    = 4'd6,
    V_NOT_OURS    = 4'd7,
    V_UNSUPPORTED = 4'd8
  } verdict_t;

  typedef struct packed {
    logic [15:0] hw0;
    logic [15:0] hw1;
    logic [15:0] hw2;
    logic [15:0] hw3;
    logic [15:0] hw4;
    logic [15:0] hw5;
    logic [15:0] hw6;
    logic [15:0] hw7;
    logic [15:0] hw8;
    logic [15:0] hw9;
    logic [15:0] frame_bytes;
  } hdr_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [1:0]  slot_index;
    logic [31:0] source_address;
    logic [15:0] payload_bytes;
    logic [7:0]  protocol_number;
  } res_t;

  // Findings of the first stage, handed to the merge stage
  typedef struct packed {
    logic                         is_short;
    logic                         bad_version;
    logic                         has_options;
    logic                         is_fragment;
    logic                         not_ours;
    logic [PAIR_COUNT-1:0][16:0]  pair_sum;
    logic [31:0]                  source_address;
    logic [15:0]                  payload_bytes;
    logic [7:0]                   protocol_number;
  } chk_t;

endpackage

@@ hdl/ihc_in_if.sv @@
interface ihc_in_if;
  logic          valid;
  logic          ready;
  ihc_pkg::hdr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ihc_out_if.sv @@
interface ihc_out_if;
  logic          valid;
  logic          ready;
  ihc_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ipv4_rx_header_classifier_unit.sv @@
// Pipeline: an accepted header is registered in the first stage, then in the
//   output register, which offers the result on out_ch.
// Throughput: one header per cycle while out_ch takes every result; a stalled
//   result holds off intake once the first stage and the output register both
//   hold a header.
// Reset (rst_n low, synchronous): both stages empty, local address 0,
//   all handler slots empty (256).
`include "ipv4_rx_header_classifier_unit_assert.svh"

module ipv4_rx_header_classifier_unit #(
  parameter int SLOT_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ihc_in_if.sink      in_ch,
  ihc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Only the first SLOT_COUNT slots are searched, capped by the register count
  localparam int LANES = (SLOT_COUNT < ihc_pkg::SLOT_REGS) ? SLOT_COUNT
                                                            : ihc_pkg::SLOT_REGS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [31:0] local_addr_r, local_addr_nxt;
  logic [8:0]  slot_proto_r   [ihc_pkg::SLOT_REGS];
  logic [8:0]  slot_proto_nxt [ihc_pkg::SLOT_REGS];
  logic [2:0]  reg_idx;
  logic [2:0]  slot_off;
  logic        cfg_wr;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign slot_off = reg_idx - ihc_pkg::REG_SLOT_FIRST;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Write the addressed register; writes past the list are dropped
  always_comb begin
    local_addr_nxt = local_addr_r;
    slot_proto_nxt = slot_proto_r;
    if (cfg_wr) begin
      if (reg_idx == ihc_pkg::REG_LOCAL_ADDR) begin
        local_addr_nxt = pwdata;
      end else if (reg_idx inside {[ihc_pkg::REG_SLOT_FIRST:ihc_pkg::REG_SLOT_LAST]}) begin
        slot_proto_nxt[slot_off[1:0]] = pwdata[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      for (int i = 0; i < ihc_pkg::SLOT_REGS; i++) begin
        slot_proto_r[i] <= ihc_pkg::SLOT_EMPTY;
      end
    end else begin
      local_addr_r <= local_addr_nxt;
      slot_proto_r <= slot_proto_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == ihc_pkg::REG_LOCAL_ADDR) begin
      prdata = local_addr_r;
    end else if (reg_idx inside {[ihc_pkg::REG_SLOT_FIRST:ihc_pkg::REG_SLOT_LAST]}) begin
      prdata = {23'b0, slot_proto_r[slot_off[1:0]]};
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: each stage advances when it is empty or its successor moves
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_adv;
  logic s1_adv;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || out_adv;
  assign in_ch.ready = s1_adv;

  assign s1_valid_nxt  = s1_adv  ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r  : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: header field checks, checksum lanes and slot lanes
  // ---------------------------------------------------------------------
  ihc_pkg::hdr_t hdr;
  ihc_pkg::chk_t chk;
  logic [15:0]   hw_a [ihc_pkg::HW_COUNT];
  logic [LANES-1:0] hit;
  logic [3:0]    ihl;

  assign hdr = in_ch.data;
  assign ihl = hdr.hw0[11:8];

  assign hw_a[0] = hdr.hw0;
  assign hw_a[1] = hdr.hw1;
  assign hw_a[2] = hdr.hw2;
  assign hw_a[3] = hdr.hw3;
  assign hw_a[4] = hdr.hw4;
  assign hw_a[5] = hdr.hw5;
  assign hw_a[6] = hdr.hw6;
  assign hw_a[7] = hdr.hw7;
  assign hw_a[8] = hdr.hw8;
  assign hw_a[9] = hdr.hw9;

  for (genvar g = 0; g < ihc_pkg::PAIR_COUNT; g++) begin : g_sum
    ihc_sum_lane u_sum (
      .hw_a     (hw_a[2*g]),
      .hw_b     (hw_a[2*g+1]),
      .pair_sum (chk.pair_sum[g])
    );
  end

  for (genvar g = 0; g < LANES; g++) begin : g_slot
    ihc_slot_lane u_slot (
      .protocol_number (hdr.hw4[7:0]),
      .slot_protocol   (slot_proto_r[g]),
      .hit             (hit[g])
    );
  end

  assign chk.is_short        = hdr.frame_bytes < ihc_pkg::HDR_BYTES;
  assign chk.bad_version     = (hdr.hw0[15:12] != ihc_pkg::IP_VERSION) ||
                               (ihl < ihc_pkg::MIN_IHL);
  assign chk.has_options     = ihl > ihc_pkg::MIN_IHL;
  assign chk.is_fragment     = ((hdr.hw3 & ihc_pkg::FRAG_MF_MASK) != '0) ||
                               ((hdr.hw3 & ihc_pkg::FRAG_OFS_MASK) != '0);
  assign chk.not_ours        = {hdr.hw8, hdr.hw9} != local_addr_r;
  assign chk.source_address  = {hdr.hw6, hdr.hw7};
  // Saturate the payload length at zero
  assign chk.payload_bytes   = (hdr.hw1 >= ihc_pkg::HDR_BYTES) ?
                               (hdr.hw1 - ihc_pkg::HDR_BYTES) : '0;
  assign chk.protocol_number = hdr.hw4[7:0];

  ihc_pkg::chk_t    s1_chk_r;
  logic [LANES-1:0] s1_hit_r;

  // Payload registers: load on each transfer into the stage, else hold
  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_chk_r <= chk;
      s1_hit_r <= hit;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: merge lane findings into the verdict, then the output register
  // ---------------------------------------------------------------------
  ihc_pkg::res_t res;
  ihc_pkg::res_t out_data_r;

  ihc_merge #(
    .LANES (LANES)
  ) u_merge (
    .chk (s1_chk_r),
    .hit (s1_hit_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A full first stage reaches the output as soon as the output can move
  `IHC_ASSERT_NEXT(a_s1_to_out, s1_valid_r && out_adv, out_valid_r)
  // An empty first stage never holds off intake
  `IHC_ASSERT_SAME(a_ready_when_empty, !s1_valid_r, in_ch.ready)
  // A slot verdict names a slot that holds the reported protocol
  `IHC_ASSERT_SAME(a_slot_matches,
    out_valid_r && (out_data_r.verdict == ihc_pkg::V_SLOT),
    slot_proto_r[out_data_r.slot_index] == {1'b0, out_data_r.protocol_number})
  // Slot index is zero unless a slot was chosen
  `IHC_ASSERT_SAME(a_slot_idx_zero,
    out_valid_r && (out_data_r.verdict != ihc_pkg::V_SLOT),
    out_data_r.slot_index == '0)

endmodule

@@ hdl/ihc_sum_lane.sv @@
// One checksum lane: add a pair of header halfwords.
module ihc_sum_lane (
  input  logic [15:0] hw_a,
  input  logic [15:0] hw_b,
  output logic [16:0] pair_sum
);

  assign pair_sum = {1'b0, hw_a} + {1'b0, hw_b};

endmodule

@@ hdl/ihc_slot_lane.sv @@
// One handler slot lane: compare the slot register with the protocol.
// Values above 255, the empty mark among them, never match.
module ihc_slot_lane (
  input  logic [7:0] protocol_number,
  input  logic [8:0] slot_protocol,
  output logic       hit
);

  assign hit = (slot_protocol == {1'b0, protocol_number});

endmodule

@@ hdl/ihc_merge.sv @@
// Merge stage: fold the lane sums into the one's-complement checksum,
// pick the first slot hit and apply the check priority.
module ihc_merge #(
  parameter int LANES = 4
) (
  input  ihc_pkg::chk_t     chk,
  input  logic [LANES-1:0]  hit,
  output ihc_pkg::res_t     res
);

  logic [19:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        sum_ok;
  logic        found;
  logic [1:0]  first_slot;

  always_comb begin
    total = '0;
    for (int p = 0; p < ihc_pkg::PAIR_COUNT; p++) begin
      total = total + {3'b0, chk.pair_sum[p]};
    end
  end

  // Sum mod 0xffff is zero when the folded value is all zeros or all ones
  assign fold1  = {1'b0, total[15:0]} + {13'b0, total[19:16]};
  assign fold2  = fold1[15:0] + {15'b0, fold1[16]};
  assign sum_ok = (fold2 == '0) || (fold2 == ihc_pkg::ONES16);

  // Lowest-numbered hit wins
  always_comb begin
    found      = 1'b0;
    first_slot = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found      = 1'b1;
        first_slot = 2'(i);
      end
    end
  end

  always_comb begin
    res.slot_index      = '0;
    res.source_address  = chk.source_address;
    res.payload_bytes   = chk.payload_bytes;
    res.protocol_number = chk.protocol_number;
    if (chk.is_short) begin
      res.verdict = ihc_pkg::V_SHORT;
    end else if (chk.bad_version) begin
      res.verdict = ihc_pkg::V_VERSION;
    end else if (chk.has_options) begin
      res.verdict = ihc_pkg::V_OPTIONS;
    end else if (chk.is_fragment) begin
      res.verdict = ihc_pkg::V_FRAGMENT;
    end else if (!sum_ok) begin
      res.verdict = ihc_pkg::V_CHECKSUM;
    end else if (chk.not_ours) begin
      res.verdict = ihc_pkg::V_NOT_OURS;
    end else if (found) begin
      res.verdict    = ihc_pkg::V_SLOT;
      res.slot_index = first_slot;
    end else if (chk.protocol_number == ihc_pkg::PROTO_ICMP) begin
      res.verdict = ihc_pkg::V_ICMP;
    end else begin
      res.verdict = ihc_pkg::V_UNSUPPORTED;
    end
  end

endmodule

@@ tb/sv/ipv4_rx_header_classifier_unit_test.sv @@
module ipv4_rx_header_classifier_unit_test;
  import ihc_pkg::*;

  // Handler slots the block searches; the block is built with the same count.
  localparam int SLOT_COUNT = 4;
  // Source address used by every header that base_hdr builds.
  localparam logic [31:0] SRC_ADDR = 32'hc0a8_0001;
  // Destination that the directed part installs as the local address.
  localparam logic [31:0] HOST_ADDR = 32'h0a00_0001;
  // Register indexes that decode to nothing; writes there must not stick.
  localparam logic [2:0] REG_UNUSED_LO = REG_SLOT_LAST + 3'd1;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  // Slot setting of the third random phase: icmp, top byte, beyond 255, empty.
  localparam logic [SLOT_REGS-1:0][8:0] MIXED_SLOTS = {9'd256, 9'd511, 9'd255, 9'd1};
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 156;
  localparam int MAX_GAP     = 9;
  // Cycles to watch the output after the last result, well past the latency.
  localparam int TAIL_CYCLES = 12;
  localparam int PRINT_CAP   = 200;

  typedef enum {ROW_HDR, ROW_CFG} row_kind_t;
  typedef enum {SUM_ASIS, SUM_FIX, SUM_BAD} sum_mode_t;
  typedef enum {F_SHORT, F_VERSION, F_IHL_LOW, F_OPTIONS, F_MORE_FRAGS, F_OFFSET,
                F_SUM, F_DEST} fault_t;

  typedef struct {
    row_kind_t   kind;
    hdr_t        hdr;
    bit          typed;
    res_t        want;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        res_ready = 1'b0;

  ihc_in_if  in_ch ();
  ihc_out_if out_ch ();

  assign out_ch.ready = res_ready;

  ipv4_rx_header_classifier_unit #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Shadow of the block's registers, kept in step with every write.
  logic [31:0] local_addr;
  logic [8:0]  slot_proto [SLOT_REGS];

  res_t verdicts_due [$];
  row_t directed_rows [$];
  int   mismatches = 0;
  bit   no_src_gaps = 1'b0;
  bit   no_sink_gaps = 1'b0;
  int   sink_hold = 0;
  int   sink_stall;
  res_t seen;
  res_t oldest;

  // ---------------------------------------------------------------------------
  // Header arithmetic
  // ---------------------------------------------------------------------------

  // End-around-carry sum of all ten halfwords, starting from all ones.
  // A good header leaves all ones behind.
  function automatic logic [15:0] ones_sum(hdr_t h);
    logic [15:0] words [10];
    logic [16:0] acc;
    words = '{h.hw0, h.hw1, h.hw2, h.hw3, h.hw4, h.hw5, h.hw6, h.hw7, h.hw8, h.hw9};
    acc = {1'b0, ONES16};
    foreach (words[i]) begin
      acc = acc + words[i];
      if (acc > {1'b0, ONES16}) acc = acc - {1'b0, ONES16};
    end
    return acc[15:0];
  endfunction

  // Fill in the checksum halfword so the header sums to all ones.
  function automatic hdr_t seal_sum(hdr_t h);
    h.hw5 = '0;
    h.hw5 = ONES16 - ones_sum(h);
    return h;
  endfunction

  // Expected verdict for one header under the current register settings.
  function automatic res_t classify(hdr_t h);
    res_t        r;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    ver   = h.hw0[15:12];
    ihl   = h.hw0[11:8];
    proto = h.hw4[7:0];
    // Pass-through fields come from the header whatever the verdict.
    r.slot_index      = '0;
    r.source_address  = {h.hw6, h.hw7};
    r.payload_bytes   = (h.hw1 >= HDR_BYTES) ? h.hw1 - HDR_BYTES : '0;
    r.protocol_number = proto;
    if (h.frame_bytes < HDR_BYTES)
      r.verdict = V_SHORT;
    else if (ver != IP_VERSION || ihl < MIN_IHL)
      r.verdict = V_VERSION;
    else if (ihl > MIN_IHL)
      r.verdict = V_OPTIONS;
    else if ((h.hw3 & (FRAG_MF_MASK | FRAG_OFS_MASK)) != '0)
      r.verdict = V_FRAGMENT;
    else if (ones_sum(h) != ONES16)
      r.verdict = V_CHECKSUM;
    else if ({h.hw8, h.hw9} != local_addr)
      r.verdict = V_NOT_OURS;
    else begin
      r.verdict = (proto == PROTO_ICMP) ? V_ICMP : V_UNSUPPORTED;
      // Walk the slots from the back so the lowest match wins; a slot that
      // holds protocol 1 takes it ahead of the icmp fallback.
      for (int i = SLOT_REGS - 1; i >= 0; i--) begin
        if (i < SLOT_COUNT && slot_proto[i] == {1'b0, proto}) begin
          r.verdict    = V_SLOT;
          r.slot_index = 2'(i);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random headers
  // ---------------------------------------------------------------------------

  // Mostly well-formed headers aimed at the local address and at configured
  // protocols, so that the slot search sees real traffic; the rest carries a
  // single fault or is plain noise.
  function automatic hdr_t make_random_hdr();
    hdr_t         h;
    logic [191:0] noise;
    logic [7:0]   proto;
    logic [3:0]   bad_ver;
    fault_t       fault;
    int           pick;
    int           proto_pick;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      h = noise[175:0];
      return h;
    end
    proto_pick = $urandom_range(0, 99);
    if (proto_pick < 50)
      proto = slot_proto[$urandom_range(0, SLOT_REGS - 1)][7:0];
    else if (proto_pick < 65)
      proto = PROTO_ICMP;
    else
      proto = 8'($urandom);
    h.hw0 = {IP_VERSION, MIN_IHL, 8'($urandom)};
    h.hw1 = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
    h.hw2 = 16'($urandom);
    // Keep only DF and the reserved flag so the header is no fragment.
    h.hw3 = 16'($urandom) & 16'hc000;
    h.hw4 = {8'($urandom), proto};
    h.hw5 = '0;
    h.hw6 = 16'($urandom);
    h.hw7 = 16'($urandom);
    {h.hw8, h.hw9} = ($urandom_range(0, 99) < 85) ? local_addr : 32'($urandom);
    h.frame_bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(20, 65535))
                                                : 16'($urandom_range(20, 1518));
    fault = F_DEST;
    if (pick >= 70) begin
      fault = fault_t'($urandom_range(F_SHORT, F_DEST));
      case (fault)
        F_SHORT:      h.frame_bytes = 16'($urandom_range(0, 19));
        F_VERSION: begin
          bad_ver = 4'($urandom_range(0, 14));
          if (bad_ver >= IP_VERSION) bad_ver = bad_ver + 4'd1;
          h.hw0[15:12] = bad_ver;
        end
        F_IHL_LOW:    h.hw0[11:8] = 4'($urandom_range(0, 4));
        F_OPTIONS:    h.hw0[11:8] = 4'($urandom_range(6, 15));
        F_MORE_FRAGS: h.hw3 = h.hw3 | FRAG_MF_MASK;
        F_OFFSET:     h.hw3[12:0] = 13'($urandom_range(1, 8191));
        F_DEST:       {h.hw8, h.hw9} = $urandom;
        default: ;
      endcase
    end
    h = seal_sum(h);
    if (pick >= 70 && fault == F_SUM) h.hw5 = h.hw5 ^ 16'($urandom_range(1, 65535));
    return h;
  endfunction

  // Slot value for a random setting: empty, beyond a byte, icmp, or any byte.
  function automatic logic [8:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return SLOT_EMPTY;
    if (r < 25) return 9'($urandom_range(257, 511));
    if (r < 35) return {1'b0, PROTO_ICMP};
    return 9'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic hdr_t base_hdr(logic [31:0] dst, logic [7:0] proto);
    hdr_t h;
    h = '0;
    h.hw0 = 16'h4500;
    h.hw1 = 16'd40;
    h.hw2 = 16'h1c46;
    h.hw4 = {8'h40, proto};
    {h.hw6, h.hw7} = SRC_ADDR;
    {h.hw8, h.hw9} = dst;
    h.frame_bytes = 16'd60;
    return h;
  endfunction

  function automatic void add_hdr(hdr_t h, sum_mode_t sm, bit typed, res_t want);
    row_t row;
    if (sm != SUM_ASIS) h = seal_sum(h);
    if (sm == SUM_BAD) h.hw5 = h.hw5 ^ 16'h0001;
    row.kind    = ROW_HDR;
    row.hdr     = h;
    row.typed   = typed;
    row.want    = want;
    row.reg_idx = '0;
    row.reg_val = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
    row_t row;
    row.kind    = ROW_CFG;
    row.hdr     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  // The opening rows run on the reset settings: local address 0, no slots.
  function automatic void fill_directed();
    hdr_t h;
    add_hdr(base_hdr('0, PROTO_ICMP), SUM_FIX, 1, '{V_ICMP, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    add_hdr(base_hdr('0, 8'd6), SUM_FIX, 1, '{V_UNSUPPORTED, 2'd0, SRC_ADDR, 16'd20, 8'd6});
    h = base_hdr('0, PROTO_ICMP);
    h.frame_bytes = 16'd19;
    add_hdr(h, SUM_FIX, 1, '{V_SHORT, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    add_hdr('0, SUM_ASIS, 1, '{V_SHORT, 2'd0, 32'd0, 16'd0, 8'd0});
    add_hdr('1, SUM_ASIS, 1, '{V_VERSION, 2'd0, 32'hffff_ffff, 16'd65515, 8'hff});
    h = base_hdr('0, PROTO_ICMP);
    h.hw0 = 16'h6500;
    add_hdr(h, SUM_FIX, 1, '{V_VERSION, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h.hw0 = 16'h4400;
    add_hdr(h, SUM_FIX, 1, '{V_VERSION, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h.hw0 = 16'h4f00;
    add_hdr(h, SUM_FIX, 1, '{V_OPTIONS, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h.hw0 = 16'h4600;
    add_hdr(h, SUM_FIX, 1, '{V_OPTIONS, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h = base_hdr('0, PROTO_ICMP);
    h.hw3 = 16'h2000;
    add_hdr(h, SUM_FIX, 1, '{V_FRAGMENT, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h.hw3 = 16'h1fff;
    add_hdr(h, SUM_FIX, 1, '{V_FRAGMENT, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    h.hw3 = 16'h0001;
    add_hdr(h, SUM_FIX, 1, '{V_FRAGMENT, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    // Don't-fragment alone is no fragment.
    h.hw3 = 16'h4000;
    add_hdr(h, SUM_FIX, 0, '0);
    add_hdr(base_hdr('0, PROTO_ICMP), SUM_BAD, 1,
            '{V_CHECKSUM, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    // Payload length saturates at zero below a bare header.
    h = base_hdr('0, PROTO_ICMP);
    h.hw1 = 16'd0;
    add_hdr(h, SUM_FIX, 1, '{V_ICMP, 2'd0, SRC_ADDR, 16'd0, 8'd1});
    h.hw1 = 16'd19;
    add_hdr(h, SUM_FIX, 0, '0);
    h.hw1 = 16'hffff;
    h.frame_bytes = 16'hffff;
    add_hdr(h, SUM_FIX, 0, '0);
    add_hdr(base_hdr(HOST_ADDR, PROTO_ICMP), SUM_FIX, 1,
            '{V_NOT_OURS, 2'd0, SRC_ADDR, 16'd20, 8'd1});
    // Duplicate protocol in slots 0 and 2, icmp claimed by slot 1.
    add_cfg(REG_LOCAL_ADDR, HOST_ADDR);
    add_cfg(REG_SLOT_FIRST, 32'd6);
    add_cfg(REG_SLOT_FIRST + 3'd1, 32'd1);
    add_cfg(REG_SLOT_FIRST + 3'd2, 32'd6);
    add_cfg(REG_SLOT_LAST, 32'd255);
    add_hdr(base_hdr(HOST_ADDR, 8'd6), SUM_FIX, 0, '0);
    add_hdr(base_hdr(HOST_ADDR, PROTO_ICMP), SUM_FIX, 0, '0);
    add_hdr(base_hdr(HOST_ADDR, 8'd255), SUM_FIX, 0, '0);
    // A slot beyond a byte never matches; writes to unused indexes vanish.
    add_cfg(REG_SLOT_FIRST, 32'd511);
    add_cfg(REG_SLOT_FIRST + 3'd1, 32'd17);
    add_cfg(REG_UNUSED_LO, 32'hffff_ffff);
    add_cfg(REG_UNUSED_HI, 32'd6);
    add_hdr(base_hdr(HOST_ADDR, 8'd6), SUM_FIX, 0, '0);
    add_hdr(base_hdr(HOST_ADDR, 8'd17), SUM_FIX, 0, '0);
    add_hdr(base_hdr(HOST_ADDR, 8'd0), SUM_FIX, 0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Offer one header after a random gap, unless source gaps are off, and hold it until the transfer.
  // Leave valid high on return so a gapless next header follows directly.
  task automatic send_hdr(hdr_t h, bit typed, res_t want);
    int gap;
    gap = no_src_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= h;
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due.push_back(typed ? want : classify(h));
  endtask

  // Drop valid and hold until every pending verdict has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle phase with psel low, so back-to-back
  // writes never touch psel twice in one step.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOCAL_ADDR)
      local_addr = val;
    else if (idx >= REG_SLOT_FIRST && idx <= REG_SLOT_LAST)
      slot_proto[idx - REG_SLOT_FIRST] = val[8:0];
    @(posedge clk);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, then compare each transfer with the oldest
  // pending verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_ch.valid && res_ready) begin
      seen = out_ch.data;
      if (verdicts_due.size() == 0) begin
        report("result with nothing pending, verdict", 32'(seen.verdict), '0);
      end else begin
        oldest = verdicts_due.pop_front();
        if (seen.verdict !== oldest.verdict)
          report("verdict", 32'(seen.verdict), 32'(oldest.verdict));
        if (seen.slot_index !== oldest.slot_index)
          report("slot_index", 32'(seen.slot_index), 32'(oldest.slot_index));
        if (seen.source_address !== oldest.source_address)
          report("source_address", seen.source_address, oldest.source_address);
        if (seen.payload_bytes !== oldest.payload_bytes)
          report("payload_bytes", 32'(seen.payload_bytes), 32'(oldest.payload_bytes));
        if (seen.protocol_number !== oldest.protocol_number)
          report("protocol_number", 32'(seen.protocol_number),
                 32'(oldest.protocol_number));
      end
      // Draw the stall ahead of the next transfer.
      sink_stall = no_sink_gaps ? 0 : $urandom_range(0, MAX_GAP);
      sink_hold <= sink_stall;
      res_ready <= (sink_stall == 0);
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_hold <= 0;
      res_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    hdr_t       h;
    logic [8:0] sval;
    int         drain_at;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    local_addr = '0;
    foreach (slot_proto[i]) slot_proto[i] = SLOT_EMPTY;
    fill_directed();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: register writes wait for the block to go idle.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        reg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_hdr(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each under its own register setting. The first three
    // cover the extremes; the rest are drawn. Some phases run with no gaps
    // on one side or both so the block also sees full-rate stretches.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      no_src_gaps  = (ph % 4 == 1) || (ph % 4 == 3);
      no_sink_gaps = (ph % 4 == 2) || (ph % 4 == 3);
      if (ph == 0)
        reg_write(REG_LOCAL_ADDR, 32'hffff_ffff);
      else if (ph == 1)
        reg_write(REG_LOCAL_ADDR, 32'd0);
      else
        reg_write(REG_LOCAL_ADDR, $urandom);
      for (int r = 0; r < SLOT_REGS; r++) begin
        if (ph == 0)
          sval = 9'd0;
        else if (ph == 1)
          sval = SLOT_EMPTY;
        else if (ph == 2)
          sval = MIXED_SLOTS[r];
        else
          sval = pick_slot();
        reg_write(REG_SLOT_FIRST + 3'(r), {23'd0, sval});
      end
      // Once per phase, hold off the sender until the output runs dry.
      drain_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == drain_at) drain_results();
        h = make_random_hdr();
        send_hdr(h, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #600000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
